[design/cbo_pkg.sv]
// Shared types, constants and pointer bitmaps for the cursor bitmap overlay.
// No dependencies; used by every module of the block.

package cbo_pkg;

  // Default pointer size and built-in bitmap depth
  localparam int CursorRowsDefault = 20;
  localparam int CursorColsDefault = 16;
  localparam int BitmapRows        = 20;
  localparam int MaxRegion         = 8192;

  // Field widths
  localparam int PixelW  = 32;
  localparam int CountW  = 13;
  localparam int OffsetW = 14;
  localparam int SizeW   = 14;
  localparam int PosW    = 16;
  localparam int DeltaW  = 17;
  localparam int ModeW   = 2;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 32;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_X_OFFSET      = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_Y_OFFSET      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_REGION_WIDTH  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_REGION_HEIGHT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_POINTER_X     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_POINTER_Y     = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_PIXEL_MODE    = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_COLOR_MASK    = 3'd7;

  // Pixel modes
  localparam logic [ModeW-1:0] MODE_8BPP  = 2'd0;
  localparam logic [ModeW-1:0] MODE_16BPP = 2'd1;
  localparam logic [ModeW-1:0] MODE_24BPP = 2'd2;
  localparam logic [ModeW-1:0] MODE_32BPP = 2'd3;

  // Pointer bitmaps, bit c of a row is column c
  localparam logic [15:0] PTR_BLACK [BitmapRows] = '{
    16'd0,     16'd49152, 16'd40960, 16'd36864, 16'd34816,
    16'd33792, 16'd33280, 16'd33024, 16'd32896, 16'd32832,
    16'd33728, 16'd37376, 16'd43264, 16'd51456, 16'd1152,
    16'd1152,  16'd576,   16'd576,   16'd448,   16'd0
  };
  localparam logic [15:0] PTR_WHITE [BitmapRows] = '{
    16'd0,     16'd0,     16'd16384, 16'd24576, 16'd28672,
    16'd30720, 16'd31744, 16'd32256, 16'd32512, 16'd32640,
    16'd31744, 16'd27648, 16'd17920, 16'd1536,  16'd768,
    16'd768,   16'd384,   16'd384,   16'd0,     16'd0
  };

  // Configuration as seen by the datapath, sizes already clamped
  typedef struct packed {
    logic [SizeW-1:0]         width_eff;
    logic [SizeW-1:0]         height_eff;
    logic signed [DeltaW-1:0] dx;   // pointer column relative to region
    logic signed [DeltaW-1:0] dy;   // pointer row relative to region
    logic [ModeW-1:0]         pixel_mode;
    logic [PixelW-1:0]        color_mask;
  } cfg_t;

  // One pixel with its position, held in the input register
  typedef struct packed {
    logic [PixelW-1:0] pixel;
    logic [CountW-1:0] col;
    logic [CountW-1:0] row;
  } item_t;

  // Clamp a region size: 0 acts as 1, above MaxRegion acts as MaxRegion
  function automatic logic [SizeW-1:0] clamp_size(input logic [SizeW-1:0] v);
    logic [SizeW-1:0] r;
    r = v;
    if (v == '0) r = SizeW'(1);
    else if (v > SizeW'(MaxRegion)) r = SizeW'(MaxRegion);
    return r;
  endfunction

endpackage

[design/cbo_tracker.sv]
// Input register and raster position counters for the cursor overlay.
// Depends on cbo_pkg.

module cbo_tracker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_beat,      // pixel accepted this cycle
  input  logic [cbo_pkg::PixelW-1:0]  in_pixel,
  input  logic                        in_start,
  input  logic                        advance,      // input register drains
  input  cbo_pkg::cfg_t               cfg,
  output logic                        item_valid,
  output cbo_pkg::item_t              item
);

  logic [cbo_pkg::CountW-1:0] column_count;
  logic [cbo_pkg::CountW-1:0] row_count;
  logic [cbo_pkg::CountW-1:0] col_cur;
  logic [cbo_pkg::CountW-1:0] row_cur;
  logic [cbo_pkg::CountW-1:0] column_count_next;
  logic [cbo_pkg::CountW-1:0] row_count_next;
  logic [cbo_pkg::SizeW-1:0]  col_inc;
  logic [cbo_pkg::SizeW-1:0]  row_inc;

  // Position of this pixel; frame start places it at the origin
  assign col_cur = in_start ? '0 : column_count;
  assign row_cur = in_start ? '0 : row_count;
  assign col_inc = {1'b0, col_cur} + cbo_pkg::SizeW'(1);
  assign row_inc = {1'b0, row_cur} + cbo_pkg::SizeW'(1);

  // Raster advance with wrap at region width and height
  always_comb begin
    if (col_inc >= cfg.width_eff) begin
      column_count_next = '0;
      row_count_next    = (row_inc >= cfg.height_eff) ? '0 : row_inc[cbo_pkg::CountW-1:0];
    end else begin
      column_count_next = col_inc[cbo_pkg::CountW-1:0];
      row_count_next    = row_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      item_valid   <= 1'b0;
    end else begin
      if (in_beat) begin
        column_count <= column_count_next;
        row_count    <= row_count_next;
        item_valid   <= 1'b1;
      end else if (advance) begin
        item_valid <= 1'b0;
      end
    end
  end

  // Payload of the input register
  always_ff @(posedge clk) begin
    if (in_beat) begin
      item.pixel <= in_pixel;
      item.col   <= col_cur;
      item.row   <= row_cur;
    end
  end

endmodule

[design/cbo_overlay.sv]
// Per-pixel pointer window test, bitmap lookup and color blend.
// Depends on cbo_pkg; purely combinational.

module cbo_overlay #(
  parameter int CURSOR_ROWS = cbo_pkg::CursorRowsDefault,
  parameter int CURSOR_COLS = cbo_pkg::CursorColsDefault
) (
  input  cbo_pkg::item_t              item,
  input  cbo_pkg::cfg_t               cfg,
  output logic [cbo_pkg::PixelW-1:0]  pixel_out,
  output logic                        under
);

  localparam int DiffW = cbo_pkg::CountW + 2;

  logic              origin_in;
  logic              in_region;
  logic [DiffW-1:0]  lc;
  logic [DiffW-1:0]  lr;
  logic              col_hit;
  logic              row_hit;
  logic              blk;
  logic              wht;
  logic [15:0]       blk_row;
  logic [15:0]       wht_row;
  logic [15:0]       mask16;

  // Pointer origin must lie inside the region
  assign origin_in = !cfg.dx[cbo_pkg::DeltaW-1] && !cfg.dy[cbo_pkg::DeltaW-1] &&
                     (cfg.dx[cbo_pkg::DeltaW-2:0] < 16'(cfg.width_eff)) &&
                     (cfg.dy[cbo_pkg::DeltaW-2:0] < 16'(cfg.height_eff));
  assign in_region = ({1'b0, item.col} < cfg.width_eff) &&
                     ({1'b0, item.row} < cfg.height_eff);

  // Offset inside the pointer; dx, dy fit 13 bits whenever origin_in holds
  assign lc = {2'b00, item.col} - {2'b00, cfg.dx[cbo_pkg::CountW-1:0]};
  assign lr = {2'b00, item.row} - {2'b00, cfg.dy[cbo_pkg::CountW-1:0]};
  assign col_hit = !lc[DiffW-1] && (lc[DiffW-2:0] < (DiffW-1)'(CURSOR_COLS));
  assign row_hit = !lr[DiffW-1] && (lr[DiffW-2:0] < (DiffW-1)'(CURSOR_ROWS));
  assign under = origin_in && in_region && col_hit && row_hit;

  // Bitmap rows; pointer rows past the built-in bitmap are transparent
  always_comb begin
    blk_row = '0;
    wht_row = '0;
    if (lr[DiffW-2:0] < (DiffW-1)'(cbo_pkg::BitmapRows)) begin
      blk_row = cbo_pkg::PTR_BLACK[lr[4:0]];
      wht_row = cbo_pkg::PTR_WHITE[lr[4:0]];
    end
  end
  assign blk = blk_row[lc[3:0]];
  assign wht = wht_row[lc[3:0]];
  assign mask16 = cfg.color_mask[15:0];

  // Blend by pixel mode; white wins over black
  always_comb begin
    pixel_out = item.pixel;
    if (under) begin
      unique case (cfg.pixel_mode)
        cbo_pkg::MODE_32BPP: begin
          if (wht)      pixel_out = item.pixel | cfg.color_mask;
          else if (blk) pixel_out = item.pixel & ~cfg.color_mask;
        end
        cbo_pkg::MODE_16BPP: begin
          if (wht)      pixel_out = item.pixel | {16'h0000, mask16};
          else if (blk) pixel_out = item.pixel & ~{16'h0000, mask16};
        end
        cbo_pkg::MODE_8BPP: begin
          if (wht)      pixel_out = {item.pixel[31:8], 8'h01};
          else if (blk) pixel_out = {item.pixel[31:8], 8'h00};
        end
        default: pixel_out = item.pixel;
      endcase
    end
  end

endmodule

[design/cursor_bitmap_overlay.sv]
// Top level of the cursor bitmap overlay: configuration registers,
// handshake and result register. Depends on cbo_pkg, cbo_tracker, cbo_overlay.

// Lays a 16x20 two-bitmap mouse pointer over a raster-order pixel stream.
// One pixel is taken every clock at full rate while the output is not stalled.
// The input register loads on the accepting edge and the result register
// loads from it through the combinational window test and blend once the
// output is free; a sink stall can hold a pixel in the input register. A
// pixel with tuser set starts a new frame at column 0, row 0. Registers are
// written through cfg_we/cfg_index/cfg_data and must only change while the
// stream is idle. The pointer is drawn only when its top-left corner lies
// within the capture region, and is clipped at the region's right and bottom
// edges.

module cursor_bitmap_overlay #(
  parameter int CURSOR_ROWS = cbo_pkg::CursorRowsDefault,
  parameter int CURSOR_COLS = cbo_pkg::CursorColsDefault
) (
  input  logic                         clk,
  input  logic                         rst,
  // pixel input
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [31:0]                  s_axis_tdata,   // [31:0] pixel_in
  input  logic                         s_axis_tuser,   // [0] frame_start
  // pixel output
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [31:0]                  m_axis_tdata,   // [31:0] pixel_out
  output logic                         m_axis_tuser,   // [0] under_pointer
  // configuration writes
  input  logic                         cfg_we,
  input  logic [cbo_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [cbo_pkg::CfgW-1:0]     cfg_data
);

  logic [cbo_pkg::OffsetW-1:0] x_offset;
  logic [cbo_pkg::OffsetW-1:0] y_offset;
  logic [cbo_pkg::SizeW-1:0]   region_width;
  logic [cbo_pkg::SizeW-1:0]   region_height;
  logic [cbo_pkg::PosW-1:0]    cursor_x;
  logic [cbo_pkg::PosW-1:0]    cursor_y;
  logic [cbo_pkg::ModeW-1:0]   pixel_mode;
  logic [cbo_pkg::PixelW-1:0]  color_mask;

  cbo_pkg::cfg_t               cfg;
  cbo_pkg::item_t              item;
  logic                        item_valid;
  logic                        out_free;
  logic                        advance;
  logic                        in_beat;
  logic [cbo_pkg::PixelW-1:0]  blend_pixel;
  logic                        blend_under;

  // Configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      x_offset      <= '0;
      y_offset      <= '0;
      region_width  <= cbo_pkg::SizeW'(640);
      region_height <= cbo_pkg::SizeW'(480);
      cursor_x      <= '1;
      cursor_y      <= '1;
      pixel_mode    <= cbo_pkg::MODE_32BPP;
      color_mask    <= 32'h00FF_FFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cbo_pkg::REG_X_OFFSET:      x_offset      <= cfg_data[cbo_pkg::OffsetW-1:0];
        cbo_pkg::REG_Y_OFFSET:      y_offset      <= cfg_data[cbo_pkg::OffsetW-1:0];
        cbo_pkg::REG_REGION_WIDTH:  region_width  <= cfg_data[cbo_pkg::SizeW-1:0];
        cbo_pkg::REG_REGION_HEIGHT: region_height <= cfg_data[cbo_pkg::SizeW-1:0];
        cbo_pkg::REG_POINTER_X:     cursor_x      <= cfg_data[cbo_pkg::PosW-1:0];
        cbo_pkg::REG_POINTER_Y:     cursor_y      <= cfg_data[cbo_pkg::PosW-1:0];
        cbo_pkg::REG_PIXEL_MODE:    pixel_mode    <= cfg_data[cbo_pkg::ModeW-1:0];
        cbo_pkg::REG_COLOR_MASK:    color_mask    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Datapath view of the configuration
  always_comb begin
    cfg.width_eff  = cbo_pkg::clamp_size(region_width);
    cfg.height_eff = cbo_pkg::clamp_size(region_height);
    cfg.dx         = $signed({cursor_x[cbo_pkg::PosW-1], cursor_x}) -
                     $signed({3'b000, x_offset});
    cfg.dy         = $signed({cursor_y[cbo_pkg::PosW-1], cursor_y}) -
                     $signed({3'b000, y_offset});
    cfg.pixel_mode = pixel_mode;
    cfg.color_mask = color_mask;
  end

  // Two-stage flow control
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign advance       = item_valid && out_free;
  assign s_axis_tready = !item_valid || out_free;
  assign in_beat       = s_axis_tvalid && s_axis_tready;

  cbo_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .in_beat    (in_beat),
    .in_pixel   (s_axis_tdata),
    .in_start   (s_axis_tuser),
    .advance    (advance),
    .cfg        (cfg),
    .item_valid (item_valid),
    .item       (item)
  );

  cbo_overlay #(
    .CURSOR_ROWS (CURSOR_ROWS),
    .CURSOR_COLS (CURSOR_COLS)
  ) u_overlay (
    .item      (item),
    .cfg       (cfg),
    .pixel_out (blend_pixel),
    .under     (blend_under)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_free) begin
      m_axis_tvalid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= blend_pixel;
      m_axis_tuser <= blend_under;
    end
  end

endmodule

[tb/cursor_bitmap_overlay_tb.sv]
// Self-checking testbench for cursor_bitmap_overlay: streams frames of pixels,
// predicts each overlaid pixel and the pointer window flag, compares in order.
// Depends on cbo_pkg and the cursor_bitmap_overlay RTL.

module cursor_bitmap_overlay_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbo_pkg::*;

  localparam int POINTER_ROWS = 20;
  localparam int POINTER_COLS = 16;
  localparam int TOTAL_ITEMS  = 920;
  localparam int CYCLE_LIMIT  = 400000;

  // Arrow shape, bit c of a row is pointer column c
  localparam logic [15:0] ARROW_DARK [POINTER_ROWS] = '{
    16'h0000, 16'hC000, 16'hA000, 16'h9000, 16'h8800,
    16'h8400, 16'h8200, 16'h8100, 16'h8080, 16'h8040,
    16'h83C0, 16'h9200, 16'hA900, 16'hC900, 16'h0480,
    16'h0480, 16'h0240, 16'h0240, 16'h01C0, 16'h0000
  };
  localparam logic [15:0] ARROW_LIGHT [POINTER_ROWS] = '{
    16'h0000, 16'h0000, 16'h4000, 16'h6000, 16'h7000,
    16'h7800, 16'h7C00, 16'h7E00, 16'h7F00, 16'h7F80,
    16'h7C00, 16'h6C00, 16'h4600, 16'h0600, 16'h0300,
    16'h0300, 16'h0180, 16'h0180, 16'h0000, 16'h0000
  };

  typedef enum int {PACE_FULL, PACE_SRC_GAPS, PACE_SINK_STALLS, PACE_BOTH} pace_t;

  typedef struct packed {
    logic [PixelW-1:0] pixel;
    logic              first;
  } pixel_beat_t;

  typedef struct packed {
    logic [PixelW-1:0] pixel;
    logic              under;
  } overlay_result_t;

  typedef struct {
    logic [OffsetW-1:0] x_off;
    logic [OffsetW-1:0] y_off;
    logic [SizeW-1:0]   width;
    logic [SizeW-1:0]   height;
    logic [PosW-1:0]    ptr_x;
    logic [PosW-1:0]    ptr_y;
    logic [ModeW-1:0]   mode;
    logic [PixelW-1:0]  mask;
  } overlay_setup_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [31:0]        s_axis_tdata = '0;
  logic               s_axis_tuser = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [31:0]        m_axis_tdata;
  logic               m_axis_tuser;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgW-1:0]    cfg_data = '0;

  // Shadow of the register file and the raster position
  logic [OffsetW-1:0] cfg_x_off;
  logic [OffsetW-1:0] cfg_y_off;
  logic [SizeW-1:0]   cfg_width;
  logic [SizeW-1:0]   cfg_height;
  logic [PosW-1:0]    cfg_ptr_x;
  logic [PosW-1:0]    cfg_ptr_y;
  logic [ModeW-1:0]   cfg_mode;
  logic [PixelW-1:0]  cfg_mask;
  logic [CountW-1:0]  pos_col;
  logic [CountW-1:0]  pos_row;

  pixel_beat_t     pixel_queue[$];
  overlay_result_t expected_pixels[$];
  pace_t           pace = PACE_FULL;
  int              mismatches = 0;
  int              items_queued = 0;
  int              cycles = 0;

  cursor_bitmap_overlay DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Region size as the datapath sees it: 0 acts as 1, capped at 8192
  function automatic int region_extent(input logic [SizeW-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MaxRegion) return MaxRegion;
    return int'(v);
  endfunction

  // Overlay one pixel at the current raster position, then advance it
  function automatic overlay_result_t overlay_pixel(input logic [PixelW-1:0] pix,
                                                    input logic first);
    int w, h, dx, dy, col, row, lc, lr;
    logic dark, light;
    logic [PixelW-1:0] m;
    overlay_result_t r;
    w = region_extent(cfg_width);
    h = region_extent(cfg_height);
    dx = int'($signed(cfg_ptr_x)) - int'(cfg_x_off);
    dy = int'($signed(cfg_ptr_y)) - int'(cfg_y_off);
    r.pixel = pix;
    r.under = 1'b0;
    if (first) begin
      pos_col = '0;
      pos_row = '0;
    end
    col = int'(pos_col);
    row = int'(pos_row);
    lc = col - dx;
    lr = row - dy;
    // pointer corner must sit in the region; window clipped at right/bottom
    if (dx >= 0 && dx < w && dy >= 0 && dy < h && col < w && row < h &&
        lc >= 0 && lc < POINTER_COLS && lr >= 0 && lr < POINTER_ROWS) begin
      r.under = 1'b1;
      dark = ARROW_DARK[lr][lc];
      light = ARROW_LIGHT[lr][lc];
      case (cfg_mode)
        MODE_32BPP: begin
          if (dark) r.pixel = r.pixel & ~cfg_mask;
          if (light) r.pixel = r.pixel | cfg_mask;
        end
        MODE_16BPP: begin
          m = {16'h0000, cfg_mask[15:0]};
          if (dark) r.pixel = r.pixel & ~m;
          if (light) r.pixel = r.pixel | m;
        end
        MODE_8BPP: begin
          if (light) r.pixel = {r.pixel[31:8], 8'h01};
          else if (dark) r.pixel[7:0] = 8'h00;
        end
        default: ;
      endcase
    end
    // raster advance, wrapping at the region edges
    if (col + 1 >= w) begin
      pos_col = '0;
      pos_row = (row + 1 >= h) ? '0 : CountW'(row + 1);
    end else begin
      pos_col = CountW'(col + 1);
    end
    return r;
  endfunction

  function automatic logic source_gap();
    case (pace)
      PACE_SRC_GAPS: return $urandom_range(0, 99) < 75;
      PACE_BOTH:     return $urandom_range(0, 99) < 15;
      default:       return 1'b0;
    endcase
  endfunction

  function automatic logic sink_stall();
    case (pace)
      PACE_SINK_STALLS: return $urandom_range(0, 99) < 75;
      PACE_BOTH:        return $urandom_range(0, 99) < 15;
      default:          return 1'b0;
    endcase
  endfunction

  // Pixel source: predicts on every accepted beat, holds valid until taken
  always @(posedge clk) begin
    logic send;
    pixel_beat_t nxt;
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_pixels.push_back(overlay_pixel(s_axis_tdata, s_axis_tuser));
      if (!s_axis_tvalid || s_axis_tready) begin
        send = pixel_queue.size() != 0 && !source_gap();
        if (send) begin
          nxt = pixel_queue.pop_front();
          s_axis_tdata <= nxt.pixel;
          s_axis_tuser <= nxt.first;
        end
        s_axis_tvalid <= send;
      end
    end
  end

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch %0d: %s", mismatches, msg);
  endtask

  // Result sink: in-order compare against the predicted pixels
  always @(posedge clk) begin
    overlay_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_pixels.size() == 0) begin
        note_mismatch($sformatf("unexpected beat pixel_out %h under_pointer %0d",
                                m_axis_tdata, m_axis_tuser));
      end else begin
        want = expected_pixels.pop_front();
        if (m_axis_tdata !== want.pixel || m_axis_tuser !== want.under)
          note_mismatch($sformatf("pixel_out exp %h got %h, under_pointer exp %0d got %0d",
                                  want.pixel, m_axis_tdata, want.under, m_axis_tuser));
      end
    end
    m_axis_tready <= !sink_stall();
  end

  function automatic void push_beat(input logic [PixelW-1:0] pix, input logic first);
    pixel_beat_t b;
    b.pixel = pix;
    b.first = first;
    pixel_queue.push_back(b);
    items_queued++;
  endfunction

  function automatic logic [PixelW-1:0] rand_pixel();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic wait_idle();
    while (pixel_queue.size() != 0 || s_axis_tvalid || expected_pixels.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      REG_X_OFFSET:      cfg_x_off = val[OffsetW-1:0];
      REG_Y_OFFSET:      cfg_y_off = val[OffsetW-1:0];
      REG_REGION_WIDTH:  cfg_width = val[SizeW-1:0];
      REG_REGION_HEIGHT: cfg_height = val[SizeW-1:0];
      REG_POINTER_X:     cfg_ptr_x = val[PosW-1:0];
      REG_POINTER_Y:     cfg_ptr_y = val[PosW-1:0];
      REG_PIXEL_MODE:    cfg_mode = val[ModeW-1:0];
      REG_COLOR_MASK:    cfg_mask = val[PixelW-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setup(input overlay_setup_t s);
    write_reg(REG_X_OFFSET, CfgW'(s.x_off));
    write_reg(REG_Y_OFFSET, CfgW'(s.y_off));
    write_reg(REG_REGION_WIDTH, CfgW'(s.width));
    write_reg(REG_REGION_HEIGHT, CfgW'(s.height));
    write_reg(REG_POINTER_X, CfgW'(s.ptr_x));
    write_reg(REG_POINTER_Y, CfgW'(s.ptr_y));
    write_reg(REG_PIXEL_MODE, CfgW'(s.mode));
    write_reg(REG_COLOR_MASK, CfgW'(s.mask));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Mostly small regions with the pointer corner inside, near the top rows
  function automatic overlay_setup_t random_setup();
    overlay_setup_t s;
    int we, he, dx, dy, off;
    s.x_off = ($urandom_range(0, 3) == 0) ? '0 : OffsetW'($urandom_range(0, 16383));
    s.y_off = ($urandom_range(0, 3) == 0) ? '0 : OffsetW'($urandom_range(0, 16383));
    case ($urandom_range(0, 15))
      0:       s.width = '0;
      1:       s.width = SizeW'($urandom_range(8190, 16383));
      default: s.width = SizeW'($urandom_range(1, 24));
    endcase
    case ($urandom_range(0, 15))
      0:       s.height = '0;
      1:       s.height = SizeW'($urandom_range(8190, 16383));
      default: s.height = SizeW'($urandom_range(1, 24));
    endcase
    we = region_extent(s.width);
    he = region_extent(s.height);
    off = $urandom_range(0, 2);
    if ($urandom_range(0, 4) != 0) dx = $urandom_range(0, we - 1);
    else if ($urandom_range(0, 1) != 0) dx = we + off;
    else dx = -1 - off;
    if ($urandom_range(0, 4) != 0) dy = $urandom_range(0, (he > 4) ? 3 : he - 1);
    else if ($urandom_range(0, 1) != 0) dy = he + off;
    else dy = -1 - off;
    s.ptr_x = ($urandom_range(0, 7) == 0) ? '1 : PosW'(int'(s.x_off) + dx);
    s.ptr_y = ($urandom_range(0, 7) == 0) ? '1 : PosW'(int'(s.y_off) + dy);
    s.mode = ModeW'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0:       s.mask = '0;
      1:       s.mask = '1;
      2:       s.mask = 32'h00FF_FFFF;
      default: s.mask = $urandom;
    endcase
    return s;
  endfunction

  // Mostly whole frames; some partial, some continuing without a frame start,
  // and the odd stray frame start mid-frame
  task automatic fill_frames(input int n, input int we, input int he);
    int remaining, len, roll, area;
    area = we * he;
    remaining = n;
    while (remaining > 0) begin
      roll = $urandom_range(0, 9);
      if (roll < 6) len = area;
      else len = $urandom_range(1, area + we);
      if (len > remaining) len = remaining;
      for (int i = 0; i < len; i++)
        push_beat(rand_pixel(), (i == 0 && roll != 9) || $urandom_range(0, 63) == 0);
      remaining -= len;
    end
  endtask

  initial begin
    overlay_setup_t s;
    int phase;
    int n;
    // register values after reset
    cfg_x_off = '0;
    cfg_y_off = '0;
    cfg_width = SizeW'(640);
    cfg_height = SizeW'(480);
    cfg_ptr_x = '1;
    cfg_ptr_y = '1;
    cfg_mode = MODE_32BPP;
    cfg_mask = 32'h00FF_FFFF;
    pos_col = '0;
    pos_row = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration: pointer absent, everything passes
    push_beat('0, 1'b1);
    push_beat('1, 1'b0);
    push_beat(32'h5A5A_A5A5, 1'b0);
    wait_idle();

    // Far offsets, oversize width, zero height, pointer beyond the region
    s = '{x_off: 14'd16383, y_off: 14'd16383, width: 14'd16383, height: 14'd0,
          ptr_x: 16'h7FFF, ptr_y: 16'd16383, mode: MODE_24BPP, mask: 32'hFFFF_FFFF};
    apply_setup(s);
    push_beat('1, 1'b1);
    push_beat('0, 1'b0);
    push_beat(32'h1234_5678, 1'b0);
    wait_idle();

    // Largest region, pointer at its corner: transparent top row is under
    s = '{x_off: 14'd0, y_off: 14'd0, width: 14'd8192, height: 14'd8192,
          ptr_x: 16'd0, ptr_y: 16'd0, mode: MODE_32BPP, mask: 32'hFFFF_FFFF};
    apply_setup(s);
    push_beat('0, 1'b1);
    push_beat('1, 1'b0);
    push_beat(32'hDEAD_BEEF, 1'b0);
    push_beat(32'h0000_00FF, 1'b0);
    wait_idle();

    // Tiny region, pointer clipped at right and bottom, 8 bpp, zero mask
    s = '{x_off: 14'd5, y_off: 14'd7, width: 14'd2, height: 14'd3,
          ptr_x: 16'd6, ptr_y: 16'd7, mode: MODE_8BPP, mask: 32'h0};
    apply_setup(s);
    for (int i = 0; i < 8; i++) push_beat(rand_pixel(), i == 0);
    wait_idle();

    // Pointer explicitly absent, one-pixel region, 16 bpp
    s = '{x_off: 14'd0, y_off: 14'd0, width: 14'd1, height: 14'd1,
          ptr_x: 16'hFFFF, ptr_y: 16'hFFFF, mode: MODE_16BPP, mask: 32'hFFFF_FFFF};
    apply_setup(s);
    push_beat(32'hFFFF_0000, 1'b1);
    push_beat(32'h0000_FFFF, 1'b0);
    push_beat('1, 1'b1);

    // Random phases, rotating through the idling patterns
    phase = 0;
    while (items_queued < TOTAL_ITEMS) begin
      wait_idle();
      s = random_setup();
      apply_setup(s);
      pace = pace_t'(phase % 4);
      n = $urandom_range(60, 140);
      fill_frames(n, region_extent(s.width), region_extent(s.height));
      phase++;
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
